>>> sv/fpa_pkg.sv
// Shared types and constants for the Q24.8 fixed-point arithmetic pipeline.
// Used by fpa_front, fpa_div and fixed_point_alu_q24_8; depends on nothing.

package fpa_pkg;

    // Number format
    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 8;
    localparam int PROD_W    = 2 * DATA_W;

    // Divider: dividend magnitude shifted up by the fraction, quotient bits per stage
    localparam int DIV_W      = DATA_W + FRAC_BITS;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = (DIV_W + DIV_STEPS - 1) / DIV_STEPS;

    // Input register, front stage, divider stages
    localparam int NUM_PIPE = 2 + DIV_STAGES;

    // Stream widths
    localparam int OP_W      = 4;
    localparam int S_TDATA_W = 2 * DATA_W;
    localparam int M_TUSER_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_GT       = 4'd4,
        OP_LT       = 4'd5,
        OP_GE       = 4'd6,
        OP_LE       = 4'd7,
        OP_EQ       = 4'd8,
        OP_NE       = 4'd9,
        OP_MIN      = 4'd10,
        OP_MAX      = 4'd11,
        OP_INC      = 4'd12,
        OP_DEC      = 4'd13,
        OP_TO_INT   = 4'd14,
        OP_FROM_INT = 4'd15
    } op_t;

    // Everything that rides beside the divider
    typedef struct packed {
        logic              is_div;
        logic              neg;
        logic              dz;
        logic              cmp;
        logic [DATA_W-1:0] res;
    } side_t;

    // One finished result transaction
    typedef struct packed {
        logic              dz;
        logic              cmp;
        logic [DATA_W-1:0] res;
    } result_t;

endpackage

>>> sv/fpa_front.sv
// Front stage: decodes the operation, does all non-divide work and the multiply,
// and prepares divider magnitudes. Depends on fpa_pkg.

module fpa_front (
    input  logic                              clk,
    input  logic                              en,
    input  fpa_pkg::op_t                      op,
    input  logic signed [fpa_pkg::DATA_W-1:0] a,
    input  logic signed [fpa_pkg::DATA_W-1:0] b,
    output fpa_pkg::side_t                    side,
    output logic [fpa_pkg::DIV_W-1:0]         dividend,
    output logic [fpa_pkg::DATA_W-1:0]        divisor
);

    logic signed [fpa_pkg::PROD_W-1:0] prod;
    logic                              lt;
    logic                              gt;
    logic                              eq;
    logic [fpa_pkg::DATA_W-1:0]        mag_a;
    logic [fpa_pkg::DATA_W-1:0]        mag_b;
    fpa_pkg::side_t                    side_next;
    fpa_pkg::side_t                    side_reg;
    logic [fpa_pkg::DIV_W-1:0]         dividend_reg;
    logic [fpa_pkg::DATA_W-1:0]        divisor_reg;

    // Signed compares and the full product
    assign prod  = a * b;
    assign lt    = a < b;
    assign gt    = a > b;
    assign eq    = a == b;

    // Magnitudes for the unsigned divider; the most negative value maps to 2^31
    assign mag_a = a[fpa_pkg::DATA_W-1] ? (~a + 1'b1) : a;
    assign mag_b = b[fpa_pkg::DATA_W-1] ? (~b + 1'b1) : b;

    // Decode the operation
    always_comb
    begin
        side_next        = '0;
        side_next.neg    = a[fpa_pkg::DATA_W-1] ^ b[fpa_pkg::DATA_W-1];
        unique case (op)
            fpa_pkg::OP_ADD:      side_next.res = a + b;
            fpa_pkg::OP_SUB:      side_next.res = a - b;
            fpa_pkg::OP_MUL:
                side_next.res = prod[fpa_pkg::FRAC_BITS+fpa_pkg::DATA_W-1:fpa_pkg::FRAC_BITS];
            fpa_pkg::OP_DIV:
            begin
                side_next.is_div = 1'b1;
                side_next.dz     = (b == '0);
            end
            fpa_pkg::OP_GT:       side_next.cmp = gt;
            fpa_pkg::OP_LT:       side_next.cmp = lt;
            fpa_pkg::OP_GE:       side_next.cmp = !lt;
            fpa_pkg::OP_LE:       side_next.cmp = !gt;
            fpa_pkg::OP_EQ:       side_next.cmp = eq;
            fpa_pkg::OP_NE:       side_next.cmp = !eq;
            fpa_pkg::OP_MIN:      side_next.res = lt ? a : b;
            fpa_pkg::OP_MAX:      side_next.res = gt ? a : b;
            fpa_pkg::OP_INC:      side_next.res = a + fpa_pkg::DATA_W'(1);
            fpa_pkg::OP_DEC:      side_next.res = a - fpa_pkg::DATA_W'(1);
            fpa_pkg::OP_TO_INT:   side_next.res = a >>> fpa_pkg::FRAC_BITS;
            fpa_pkg::OP_FROM_INT: side_next.res = a << fpa_pkg::FRAC_BITS;
            default:              side_next.res = '0;
        endcase
    end

    // Hold the stage while the pipeline is stalled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg     <= side_next;
            dividend_reg <= {mag_a, {fpa_pkg::FRAC_BITS{1'b0}}};
            divisor_reg  <= mag_b;
        end
    end

    assign side     = side_reg;
    assign dividend = dividend_reg;
    assign divisor  = divisor_reg;

endmodule

>>> sv/fpa_div.sv
// Pipelined restoring divider on magnitudes, DIV_STEPS quotient bits per stage,
// carrying the side-band result fields along. Depends on fpa_pkg.

module fpa_div (
    input  logic                        clk,
    input  logic                        en,
    input  logic [fpa_pkg::DIV_W-1:0]   dividend,
    input  logic [fpa_pkg::DATA_W-1:0]  divisor,
    input  fpa_pkg::side_t              side_in,
    output logic [fpa_pkg::DIV_W-1:0]   quotient,
    output fpa_pkg::side_t              side_out
);

    logic [fpa_pkg::DATA_W-1:0] rem_reg  [fpa_pkg::DIV_STAGES];
    logic [fpa_pkg::DIV_W-1:0]  dq_reg   [fpa_pkg::DIV_STAGES];
    logic [fpa_pkg::DATA_W-1:0] mb_reg   [fpa_pkg::DIV_STAGES];
    fpa_pkg::side_t             side_reg [fpa_pkg::DIV_STAGES];

    logic [fpa_pkg::DATA_W-1:0] rem_src  [fpa_pkg::DIV_STAGES];
    logic [fpa_pkg::DIV_W-1:0]  dq_src   [fpa_pkg::DIV_STAGES];
    logic [fpa_pkg::DATA_W-1:0] mb_src   [fpa_pkg::DIV_STAGES];
    fpa_pkg::side_t             side_src [fpa_pkg::DIV_STAGES];

    logic [fpa_pkg::DATA_W-1:0] rem_next [fpa_pkg::DIV_STAGES];
    logic [fpa_pkg::DIV_W-1:0]  dq_next  [fpa_pkg::DIV_STAGES];

    // Feed each stage from the one before it
    always_comb
    begin
        rem_src[0]  = '0;
        dq_src[0]   = dividend;
        mb_src[0]   = divisor;
        side_src[0] = side_in;
        for (int s = 1; s < fpa_pkg::DIV_STAGES; s++)
        begin
            rem_src[s]  = rem_reg[s-1];
            dq_src[s]   = dq_reg[s-1];
            mb_src[s]   = mb_reg[s-1];
            side_src[s] = side_reg[s-1];
        end
    end

    // Shift in a dividend bit, trial-subtract, keep or restore; dividend bits
    // leave at the top of dq while quotient bits enter at the bottom
    always_comb
    begin : div_step
        logic [fpa_pkg::DATA_W-1:0] r;
        logic [fpa_pkg::DIV_W-1:0]  q;
        logic [fpa_pkg::DATA_W:0]   sh;
        logic [fpa_pkg::DATA_W:0]   diff;
        r    = '0;
        q    = '0;
        sh   = '0;
        diff = '0;
        for (int s = 0; s < fpa_pkg::DIV_STAGES; s++)
        begin
            r = rem_src[s];
            q = dq_src[s];
            for (int k = 0; k < fpa_pkg::DIV_STEPS; k++)
            begin
                if (s * fpa_pkg::DIV_STEPS + k < fpa_pkg::DIV_W)
                begin
                    sh   = {r, q[fpa_pkg::DIV_W-1]};
                    diff = sh - {1'b0, mb_src[s]};
                    q    = {q[fpa_pkg::DIV_W-2:0], ~diff[fpa_pkg::DATA_W]};
                    r    = diff[fpa_pkg::DATA_W] ? sh[fpa_pkg::DATA_W-1:0]
                                                 : diff[fpa_pkg::DATA_W-1:0];
                end
            end
            rem_next[s] = r;
            dq_next[s]  = q;
        end
    end

    // Advance all stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < fpa_pkg::DIV_STAGES; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                dq_reg[s]   <= dq_next[s];
                mb_reg[s]   <= mb_src[s];
                side_reg[s] <= side_src[s];
            end
        end
    end

    assign quotient = dq_reg[fpa_pkg::DIV_STAGES-1];
    assign side_out = side_reg[fpa_pkg::DIV_STAGES-1];

endmodule

>>> sv/fixed_point_alu_q24_8.sv
// Top level of the Q24.8 arithmetic pipeline: input register, front stage,
// divider stages, result select and an output register with skid buffer.
// Depends on fpa_pkg, fpa_front and fpa_div.
//
//   channel   | direction | tdata                          | tuser
//   ----------+-----------+--------------------------------+---------------------------------
//   s_axis    | in        | [31:0] operand_a,[63:32] op_b  | [3:0] operation
//   m_axis    | out       | [31:0] result                  | [0] compare_true,[1] divide_by_zero
//
// One transaction per cycle while the skid buffer is empty; the divider pipeline resolves
// two quotient bits per stage for Q24.8 operands.
// Reset clears only the valid bits of the pipeline, output register and skid buffer.
// A stalled output fills the skid buffer; the whole pipeline then holds until it drains.
// s_axis_tready comes straight from a register.

module fixed_point_alu_q24_8 (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [fpa_pkg::S_TDATA_W-1:0]     s_axis_tdata,   // operand_a, operand_b
    input  logic [fpa_pkg::OP_W-1:0]          s_axis_tuser,   // operation
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [fpa_pkg::DATA_W-1:0]        m_axis_tdata,   // result
    output logic [fpa_pkg::M_TUSER_W-1:0]     m_axis_tuser    // compare_true, divide_by_zero
);

    logic [fpa_pkg::NUM_PIPE-1:0]      vld_reg;
    logic [fpa_pkg::NUM_PIPE-1:0]      vld_next;
    logic                              en;

    fpa_pkg::op_t                      op_reg;
    logic signed [fpa_pkg::DATA_W-1:0] a_reg;
    logic signed [fpa_pkg::DATA_W-1:0] b_reg;

    fpa_pkg::side_t                    front_side;
    logic [fpa_pkg::DIV_W-1:0]         front_dividend;
    logic [fpa_pkg::DATA_W-1:0]        front_divisor;
    fpa_pkg::side_t                    div_side;
    logic [fpa_pkg::DIV_W-1:0]         div_quot;

    logic [fpa_pkg::DATA_W-1:0]        quot_lo;
    logic [fpa_pkg::DATA_W-1:0]        div_res;
    fpa_pkg::result_t                  arrive;
    logic                              arrive_vld;
    logic                              take;

    logic                              out_vld_reg;
    logic                              out_vld_next;
    logic                              skid_vld_reg;
    logic                              skid_vld_next;
    fpa_pkg::result_t                  out_reg;
    fpa_pkg::result_t                  skid_reg;

    // Move the pipeline only while the skid buffer is free
    assign en            = !skid_vld_reg;
    assign s_axis_tready = en;

    // Register the incoming transaction
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg <= fpa_pkg::op_t'(s_axis_tuser);
            a_reg  <= $signed(s_axis_tdata[fpa_pkg::DATA_W-1:0]);
            b_reg  <= $signed(s_axis_tdata[fpa_pkg::S_TDATA_W-1:fpa_pkg::DATA_W]);
        end
    end

    fpa_front u_front (
        .clk      (clk),
        .en       (en),
        .op       (op_reg),
        .a        (a_reg),
        .b        (b_reg),
        .side     (front_side),
        .dividend (front_dividend),
        .divisor  (front_divisor)
    );

    fpa_div u_div (
        .clk      (clk),
        .en       (en),
        .dividend (front_dividend),
        .divisor  (front_divisor),
        .side_in  (front_side),
        .quotient (div_quot),
        .side_out (div_side)
    );

    // Apply the quotient sign and pick the result
    assign quot_lo = div_quot[fpa_pkg::DATA_W-1:0];
    assign div_res = div_side.neg ? (~quot_lo + 1'b1) : quot_lo;

    always_comb
    begin
        arrive.dz  = div_side.dz;
        arrive.cmp = div_side.cmp;
        if (div_side.is_div)
        begin
            arrive.res = div_side.dz ? '0 : div_res;
        end
        else
        begin
            arrive.res = div_side.res;
        end
    end

    assign arrive_vld = vld_reg[fpa_pkg::NUM_PIPE-1] && en;
    assign take       = out_vld_reg && m_axis_tready;

    // Valid bits: shift with the data, then output register and skid buffer
    always_comb
    begin
        vld_next      = en ? {vld_reg[fpa_pkg::NUM_PIPE-2:0], s_axis_tvalid} : vld_reg;
        out_vld_next  = out_vld_reg;
        skid_vld_next = skid_vld_reg;
        if (skid_vld_reg)
        begin
            if (take)
            begin
                skid_vld_next = 1'b0;
            end
        end
        else if (arrive_vld)
        begin
            if (out_vld_reg && !m_axis_tready)
            begin
                skid_vld_next = 1'b1;
            end
            out_vld_next = 1'b1;
        end
        else if (take)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg      <= vld_next;
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    // Output and skid payload
    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (arrive_vld)
        begin
            if (out_vld_reg && !m_axis_tready)
            begin
                skid_reg <= arrive;
            end
            else
            begin
                out_reg <= arrive;
            end
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_reg.res;
    assign m_axis_tuser  = {out_reg.dz, out_reg.cmp};

    // A zero divisor always yields a zero result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == '0)
        else $error("divide by zero with nonzero result");

    // A true comparison gives a zero result and never a divide flag
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
        else $error("compare flag with result or divide flag");

    // The skid buffer only fills behind a waiting output
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid buffer holds data with empty output register");

    // A stalled output with a full skid buffer freezes the pipeline valid bits
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg && !m_axis_tready |=> $stable(vld_reg))
        else $error("pipeline moved while skid buffer was full");

endmodule

>>> verif/tb_fixed_point_alu_q24_8.sv
// Self-checking testbench for the Q24.8 fixed-point arithmetic pipeline.
// Depends on fpa_pkg and fixed_point_alu_q24_8, and through it on fpa_front and fpa_div.
`timescale 1ns / 100ps

module tb_fixed_point_alu_q24_8;

    import fpa_pkg::*;

    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_OFF_LEN  = 400;
    localparam int DRAIN_CYCLES  = NUM_PIPE + 12;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;    // [31:0] operand_a, [63:32] operand_b
    logic [OP_W-1:0]       s_axis_tuser = '0;    // [3:0] operation
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [DATA_W-1:0]     m_axis_tdata;         // [31:0] result
    logic [M_TUSER_W-1:0]  m_axis_tuser;         // [0] compare_true, [1] divide_by_zero

    // Expected results in issue order, and run bookkeeping
    result_t pending_results[$];
    int      error_count = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      hold_cycles_req = 0;
    int      hold_left = 0;
    int      quiet_cycles = 0;

    fixed_point_alu_q24_8 dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Compute the result transaction that one operation must produce
    function automatic result_t predict_alu(op_t op, logic signed [DATA_W-1:0] a,
                                            logic signed [DATA_W-1:0] b);
        result_t             r;
        longint              sa;
        longint              sb;
        longint              prod;
        longint unsigned     mag_a;
        longint unsigned     mag_b;
        longint unsigned     quot;
        r  = '0;
        sa = a;
        sb = b;
        case (op)
            OP_ADD:      r.res = a + b;
            OP_SUB:      r.res = a - b;
            OP_MUL:
            begin
                prod  = (sa * sb) >>> FRAC_BITS;
                r.res = prod[DATA_W-1:0];
            end
            OP_DIV:
            begin
                if (b == 0)
                begin
                    r.dz = 1'b1;
                end
                else
                begin
                    // Truncate toward zero on magnitudes, then restore the sign
                    mag_a = (sa < 0) ? -sa : sa;
                    mag_b = (sb < 0) ? -sb : sb;
                    quot  = (mag_a << FRAC_BITS) / mag_b;
                    if ((sa < 0) != (sb < 0))
                        quot = -quot;
                    r.res = quot[DATA_W-1:0];
                end
            end
            OP_GT:       r.cmp = (a > b);
            OP_LT:       r.cmp = (a < b);
            OP_GE:       r.cmp = (a >= b);
            OP_LE:       r.cmp = (a <= b);
            OP_EQ:       r.cmp = (a == b);
            OP_NE:       r.cmp = (a != b);
            OP_MIN:      r.res = (a < b) ? a : b;
            OP_MAX:      r.res = (a > b) ? a : b;
            OP_INC:      r.res = a + 32'sd1;
            OP_DEC:      r.res = a - 32'sd1;
            OP_TO_INT:   r.res = a >>> FRAC_BITS;
            default:     r.res = a << FRAC_BITS;
        endcase
        return r;
    endfunction

    // Operand mix weighted toward the corners of the Q24.8 range
    function automatic logic [DATA_W-1:0] pick_operand();
        logic [DATA_W-1:0] v;
        case ($urandom_range(11))
            0:       v = '0;
            1:       v = 32'h0000_0001;
            2:       v = 32'hFFFF_FFFF;
            3:       v = 32'h7FFF_FFFF;
            4:       v = 32'h8000_0000;
            5:       v = 32'h0000_0100;
            6:       v = 32'hFFFF_FF00;
            7:       v = $urandom_range(4095) - 2048;
            8:       v = ($urandom_range(255) - 128) << FRAC_BITS;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Offer one transaction after a random idle gap; record its expectation on acceptance
    task automatic send_op(op_t op, logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(predict_alu(op, a, b));
    endtask

    // Drop valid and wait for every outstanding result
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Corners of every operation, zero divisor and wrapping cases
    task automatic test_directed_corners();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_op(OP_ADD,      32'h7FFF_FFFF, 32'h0000_0001);
        send_op(OP_SUB,      32'h8000_0000, 32'h0000_0001);
        send_op(OP_MUL,      32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_op(OP_MUL,      32'h8000_0000, 32'h8000_0000);
        send_op(OP_MUL,      32'hFFFF_FFFF, 32'h0000_0001);
        send_op(OP_MUL,      32'h0000_0180, 32'hFFFF_FE00);
        send_op(OP_DIV,      32'h0000_1234, 32'h0000_0000);
        send_op(OP_DIV,      32'h8000_0000, 32'hFFFF_FFFF);
        send_op(OP_DIV,      32'h0000_0007, 32'hFFFF_FFFE);
        send_op(OP_DIV,      32'h8000_0000, 32'h0000_0001);
        send_op(OP_DIV,      32'h7FFF_FFFF, 32'h8000_0000);
        send_op(OP_GT,       32'h7FFF_FFFF, 32'h8000_0000);
        send_op(OP_LT,       32'h8000_0000, 32'h7FFF_FFFF);
        send_op(OP_GE,       32'h8000_0000, 32'h8000_0000);
        send_op(OP_LE,       32'h0000_0001, 32'hFFFF_FFFF);
        send_op(OP_EQ,       32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_op(OP_NE,       32'h0000_0000, 32'h8000_0000);
        send_op(OP_MIN,      32'hFFFF_FF00, 32'hFFFF_FF00);
        send_op(OP_MIN,      32'h8000_0000, 32'h7FFF_FFFF);
        send_op(OP_MAX,      32'h8000_0000, 32'h7FFF_FFFF);
        send_op(OP_INC,      32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_op(OP_DEC,      32'h8000_0000, 32'h0000_0000);
        send_op(OP_TO_INT,   32'hFFFF_FFFF, 32'h1234_5678);
        send_op(OP_TO_INT,   32'h8000_0000, 32'h0000_0000);
        send_op(OP_FROM_INT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        wait_drained();
    endtask

    // Random operations under the given idle and stall rates
    task automatic test_random_stream(int count, int idle_pct, int stall_pct);
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            a = pick_operand();
            // Equal operands now and then so compares, min and max hit the tie
            b = ($urandom_range(4) == 0) ? a : pick_operand();
            send_op(op_t'($urandom_range(15)), a, b);
        end
        wait_drained();
    endtask

    // Hold the output off while the sender keeps offering, so the input backs up
    task automatic test_output_hold_off(int count);
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_cycles_req = HOLD_OFF_LEN;
        for (int i = 0; i < count; i++)
            send_op(op_t'($urandom_range(15)), pick_operand(), pick_operand());
        wait_drained();
    endtask

    // Receiver: random stalls plus an optional long hold-off
    always @(posedge clk)
    begin
        if (hold_cycles_req != 0)
        begin
            hold_left       = hold_cycles_req;
            hold_cycles_req = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no expectation: result %h, tuser %b",
                       m_axis_tdata, m_axis_tuser);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata !== want.res)
                begin
                    $error("result: expected %h, got %h", want.res, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tuser[0] !== want.cmp)
                begin
                    $error("compare_true: expected %b, got %b", want.cmp, m_axis_tuser[0]);
                    error_count++;
                end
                if (m_axis_tuser[1] !== want.dz)
                begin
                    $error("divide_by_zero: expected %b, got %b", want.dz, m_axis_tuser[1]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_random_stream(500, 0, 0);
        test_random_stream(450, 70, 0);
        test_random_stream(450, 0, 70);
        test_random_stream(400, 20, 20);
        test_output_hold_off(120);

        // Let any stray output show up before judging
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
